### hdl/pts_pkg.sv
// Shared types and codes for the priority task scheduler.
package pts_pkg;

  // Operation codes carried by an input word.
  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_DELETE = 3'd1,
    OP_DELAY  = 3'd2,
    OP_END    = 3'd3,
    OP_PICK   = 3'd4
  } op_t;

  // Status of one task slot.
  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_READY = 2'd1,
    ST_SLEEP = 2'd2
  } status_t;

  // Command word that travels down the slot chain, one cell per cycle.
  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [15:0] handle;
    logic [7:0]  prio;
    logic [31:0] delay_ms;
    logic [31:0] now_ms;
    logic        del_en;
    logic        done;
    logic        ok;
    logic        sw;
    logic [7:0]  best_prio;
  } sweep_t;

endpackage

### hdl/pts_cell.sv
// One task slot of the scheduler chain: slot state plus a sweep stage.
module pts_cell
  import pts_pkg::*;
#(
  parameter int IDX_W    = 3,
  parameter int SLOT_IDX = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cur_i,
  input  sweep_t           pkt_i,
  input  logic [IDX_W-1:0] best_i,
  output sweep_t           pkt_o,
  output logic [IDX_W-1:0] best_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT_IDX);

  status_t     status_r, status_nxt;
  logic [7:0]  prio_r, prio_nxt;
  logic [15:0] handle_r, handle_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] len_r, len_nxt;
  sweep_t      pkt_r, pkt_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  logic [31:0] elapsed;
  logic        is_cur;
  status_t     eff_status;

  // Apply the passing command word to this slot and update the word.
  always_comb begin
    status_nxt = status_r;
    prio_nxt   = prio_r;
    handle_nxt = handle_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    pkt_nxt    = pkt_i;
    best_nxt   = best_i;
    elapsed    = pkt_i.now_ms - start_r;
    is_cur     = (cur_i == MY_IDX);
    eff_status = status_r;
    if (status_r == ST_SLEEP && elapsed >= len_r) begin
      eff_status = ST_READY;
    end
    if (pkt_i.valid) begin
      unique case (pkt_i.op)
        OP_CREATE: begin
          if (!pkt_i.done && status_r == ST_FREE) begin
            status_nxt  = ST_READY;
            handle_nxt  = pkt_i.handle;
            prio_nxt    = pkt_i.prio;
            pkt_nxt.done = 1'b1;
            pkt_nxt.ok   = 1'b1;
            best_nxt     = MY_IDX;
          end
        end
        OP_DELETE: begin
          if (pkt_i.del_en && status_r != ST_FREE && handle_r == pkt_i.handle) begin
            status_nxt = ST_FREE;
            if (is_cur) begin
              pkt_nxt.sw = 1'b1;
            end
          end
        end
        OP_DELAY: begin
          if (is_cur && status_r == ST_READY) begin
            status_nxt = ST_SLEEP;
            start_nxt  = pkt_i.now_ms;
            len_nxt    = pkt_i.delay_ms;
            pkt_nxt.ok = 1'b1;
          end
        end
        OP_END: begin
          if (is_cur) begin
            status_nxt = ST_FREE;
          end
        end
        OP_PICK: begin
          status_nxt = eff_status;
          if (eff_status == ST_READY && prio_r >= pkt_i.best_prio) begin
            best_nxt          = MY_IDX;
            pkt_nxt.best_prio = prio_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Slot state and the stage register toward the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= ST_FREE;
      pkt_r.valid <= 1'b0;
    end else begin
      status_r    <= status_nxt;
      pkt_r.valid <= pkt_nxt.valid;
    end
    prio_r   <= prio_nxt;
    handle_r <= handle_nxt;
    start_r  <= start_nxt;
    len_r    <= len_nxt;
    pkt_r.op        <= pkt_nxt.op;
    pkt_r.handle    <= pkt_nxt.handle;
    pkt_r.prio      <= pkt_nxt.prio;
    pkt_r.delay_ms  <= pkt_nxt.delay_ms;
    pkt_r.now_ms    <= pkt_nxt.now_ms;
    pkt_r.del_en    <= pkt_nxt.del_en;
    pkt_r.done      <= pkt_nxt.done;
    pkt_r.ok        <= pkt_nxt.ok;
    pkt_r.sw        <= pkt_nxt.sw;
    pkt_r.best_prio <= pkt_nxt.best_prio;
    best_r          <= best_nxt;
  end

  assign pkt_o  = pkt_r;
  assign best_o = best_r;

endmodule

### hdl/priority_task_scheduler_with_sleep.sv
// Fixed-priority task scheduler with timed sleep: control, idle slot and slot chain.
//
// The command word is registered at the start edge and walks the chain of slot cells from
// slot 1 up, one cell per cycle, and a last register stage holds the result and raises the
// result strobe. busy is high for that whole time, and a start while busy is not taken. A
// new word may be started in the cycle in which out_valid is high. out_valid lasts exactly
// one cycle and cannot be held off, so the receiver must capture the result then.
module priority_task_scheduler_with_sleep
  import pts_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_task_handle,
  input  logic [7:0]  in_priority_req,
  input  logic [31:0] in_delay_ms,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  output logic        out_ok,
  output logic [2:0]  out_slot,
  output logic        out_switch_request,
  output logic [2:0]  out_current_task
);

  localparam int IDX_W = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic {
    S_IDLE,
    S_SWEEP
  } state_t;

  state_t            state_r;
  logic [15:0]       prot_r;
  logic [IDX_W-1:0]  cur_r;
  logic              slot0_sleep_r;
  logic              accept;
  op_t               op_in;
  logic              cur_is_idle;
  logic              del_en;
  sweep_t            launch_nxt;
  sweep_t            pkt    [NUM_SLOTS];
  logic [IDX_W-1:0]  best   [NUM_SLOTS];
  sweep_t            tail;
  logic [IDX_W-1:0]  tail_best;
  logic [IDX_W+2:0]  best_ext;
  logic [IDX_W+2:0]  cur_ext;
  logic [IDX_W-1:0]  cur_nxt;

  assign accept      = start && (state_r == S_IDLE);
  assign busy        = (state_r == S_SWEEP);
  assign op_in       = op_t'(in_opcode);
  assign cur_is_idle = (cur_r == '0);
  assign del_en      = (in_task_handle != prot_r);
  assign tail        = pkt[NUM_SLOTS-1];
  assign tail_best   = best[NUM_SLOTS-1];

  // Build the command word, with the flags that are known before the sweep already set.
  always_comb begin
    launch_nxt           = '0;
    launch_nxt.valid     = accept;
    launch_nxt.op        = op_in;
    launch_nxt.handle    = in_task_handle;
    launch_nxt.prio      = in_priority_req;
    launch_nxt.delay_ms  = in_delay_ms;
    launch_nxt.now_ms    = in_now_ms;
    launch_nxt.del_en    = del_en;
    unique case (op_in)
      OP_DELETE: launch_nxt.ok = del_en;
      OP_DELAY: begin
        launch_nxt.ok = cur_is_idle && !slot0_sleep_r;
        launch_nxt.sw = 1'b1;
      end
      OP_END: begin
        launch_nxt.ok = !cur_is_idle;
        launch_nxt.sw = !cur_is_idle;
      end
      OP_PICK: launch_nxt.ok = 1'b1;
      default: begin
      end
    endcase
  end

  // Pick makes the chosen slot current; other operations keep it.
  always_comb begin
    cur_nxt = cur_r;
    if (tail.valid && tail.op == OP_PICK) begin
      cur_nxt = tail_best;
    end
  end

  assign best_ext = {3'b000, tail_best};
  assign cur_ext  = {3'b000, cur_nxt};

  // Control state, idle slot, register and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      prot_r        <= '0;
      cur_r         <= '0;
      slot0_sleep_r <= 1'b0;
      out_valid     <= 1'b0;
      pkt[0].valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        prot_r <= cfg_wr_data;
      end
      pkt[0].valid <= launch_nxt.valid;
      out_valid    <= tail.valid;
      cur_r        <= cur_nxt;
      if (accept && op_in == OP_DELAY && cur_is_idle) begin
        slot0_sleep_r <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (tail.valid) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    pkt[0].op          <= launch_nxt.op;
    pkt[0].handle      <= launch_nxt.handle;
    pkt[0].prio        <= launch_nxt.prio;
    pkt[0].delay_ms    <= launch_nxt.delay_ms;
    pkt[0].now_ms      <= launch_nxt.now_ms;
    pkt[0].del_en      <= launch_nxt.del_en;
    pkt[0].done        <= launch_nxt.done;
    pkt[0].ok          <= launch_nxt.ok;
    pkt[0].sw          <= launch_nxt.sw;
    pkt[0].best_prio   <= launch_nxt.best_prio;
    best[0]            <= '0;
    out_ok             <= tail.ok;
    out_slot           <= best_ext[2:0];
    out_switch_request <= tail.sw;
    out_current_task   <= cur_ext[2:0];
  end

  // Chain of slot cells, slots 1 and up.
  for (genvar i = 1; i < NUM_SLOTS; i++) begin : g_cell
    pts_cell #(
      .IDX_W    (IDX_W),
      .SLOT_IDX (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cur_i  (cur_r),
      .pkt_i  (pkt[i-1]),
      .best_i (best[i-1]),
      .pkt_o  (pkt[i]),
      .best_o (best[i])
    );
  end

  // A result only follows a sweep in progress.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an operation in progress");

  // An accepted word keeps the block busy until its result.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted word did not start a sweep");

  // A rejected operation never reports a slot.
  a_reject_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_slot == 3'd0))
    else $error("rejected operation reported a slot");

  // The strobe lasts one cycle.
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule
